@@ src/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
package lr_pkg;

    // Pixel budget of one line and the width of the pixel counter.
    localparam int MAX_PIXELS = 64;
    localparam int STEP_W     = 7;

    // Command queue between the setup front end and the stepper.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_RUN
    } t_back_state;

endpackage

@@ src/lr_front.sv @@
// Line setup: takes a request, works out deltas, directions, major axis and pixel count.
module lr_front #(
    parameter int COORD_BITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [COORD_BITS-1:0]        i_start_x,
    input  logic [COORD_BITS-1:0]        i_start_y,
    input  logic [COORD_BITS-1:0]        i_end_x,
    input  logic [COORD_BITS-1:0]        i_end_y,
    output logic                         o_push,
    input  logic                         i_full,
    output logic [COORD_BITS-1:0]        o_x0,
    output logic [COORD_BITS-1:0]        o_y0,
    output logic                         o_xneg,
    output logic                         o_yneg,
    output logic                         o_xmajor,
    output logic [COORD_BITS-1:0]        o_major,
    output logic [COORD_BITS-1:0]        o_minor,
    output logic [lr_pkg::STEP_W-1:0]    o_steps
);
    import lr_pkg::*;

    localparam int CMP_W = (COORD_BITS > STEP_W) ? COORD_BITS : STEP_W;

    logic                  r_valid, n_valid;
    logic [COORD_BITS-1:0] r_x0, r_y0, r_major, r_minor;
    logic                  r_xneg, r_yneg, r_xmajor;
    logic [STEP_W-1:0]     r_steps;

    logic                  c_xneg, c_yneg, c_xmajor;
    logic [COORD_BITS-1:0] c_dx, c_dy, c_major, c_minor;
    logic [STEP_W-1:0]     c_steps;
    logic                  accept;

    assign o_busy = r_valid & i_full;
    assign accept = i_start & ~o_busy;
    assign o_push = r_valid & ~i_full;

    always_comb begin
        c_xneg   = i_end_x < i_start_x;
        c_yneg   = i_end_y < i_start_y;
        c_dx     = c_xneg ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        c_dy     = c_yneg ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        c_xmajor = c_dx >= c_dy;
        c_major  = c_xmajor ? c_dx : c_dy;
        c_minor  = c_xmajor ? c_dy : c_dx;
        // zero-length line still plots its start point; clamp long lines
        if (c_major == '0) begin
            c_steps = STEP_W'(1);
        end else if (CMP_W'(c_major) > CMP_W'(MAX_PIXELS)) begin
            c_steps = STEP_W'(MAX_PIXELS);
        end else begin
            c_steps = STEP_W'(c_major);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x0     <= i_start_x;
            r_y0     <= i_start_y;
            r_xneg   <= c_xneg;
            r_yneg   <= c_yneg;
            r_xmajor <= c_xmajor;
            r_major  <= c_major;
            r_minor  <= c_minor;
            r_steps  <= c_steps;
        end
    end

    assign o_x0     = r_x0;
    assign o_y0     = r_y0;
    assign o_xneg   = r_xneg;
    assign o_yneg   = r_yneg;
    assign o_xmajor = r_xmajor;
    assign o_major  = r_major;
    assign o_minor  = r_minor;
    assign o_steps  = r_steps;

endmodule

@@ src/lr_queue.sv @@
// Two-entry command queue with registered read data.
module lr_queue #(
    parameter int DATA_W = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_rd_data
);
    import lr_pkg::*;

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]     r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_count = r_count;
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/lr_back.sv @@
// Bresenham stepper: emits one pixel per cycle for the line at the queue head.
module lr_back #(
    parameter int COORD_BITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  logic [COORD_BITS-1:0]        i_x0,
    input  logic [COORD_BITS-1:0]        i_y0,
    input  logic                         i_xneg,
    input  logic                         i_yneg,
    input  logic                         i_xmajor,
    input  logic [COORD_BITS-1:0]        i_major,
    input  logic [COORD_BITS-1:0]        i_minor,
    input  logic [lr_pkg::STEP_W-1:0]    i_steps,
    output logic                         o_pixel_valid,
    output logic [COORD_BITS-1:0]        o_pixel_x,
    output logic [COORD_BITS-1:0]        o_pixel_y,
    output logic                         o_last_pixel
);
    import lr_pkg::*;

    t_back_state r_state, n_state;

    logic [COORD_BITS-1:0] r_x, r_y, r_major, r_minor;
    logic                  r_xneg, r_yneg, r_xmajor;
    logic [COORD_BITS:0]   r_err;
    logic [STEP_W-1:0]     r_cnt, r_steps;

    logic [COORD_BITS:0]   err_sum, err_next;
    logic                  minor_step, last;
    logic [COORD_BITS-1:0] x_step, y_step;

    assign last       = (r_cnt + 1'b1) == r_steps;
    assign err_sum    = {1'b0, r_err[COORD_BITS-1:0]} + {1'b0, r_minor};
    assign minor_step = err_sum >= {1'b0, r_major};
    assign err_next   = minor_step ? (err_sum - {1'b0, r_major}) : err_sum;
    assign x_step     = r_xneg ? (r_x - 1'b1) : (r_x + 1'b1);
    assign y_step     = r_yneg ? (r_y - 1'b1) : (r_y + 1'b1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_LOAD;
                end
            end
            BK_LOAD: n_state = BK_RUN;
            BK_RUN: begin
                if (last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop         = 1'b0;
        o_pixel_valid = 1'b0;
        o_last_pixel  = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = ~i_empty;
            BK_RUN: begin
                o_pixel_valid = 1'b1;
                o_last_pixel  = last;
            end
            default: begin
                o_pop         = 1'b0;
                o_pixel_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_LOAD) begin
            r_x      <= i_x0;
            r_y      <= i_y0;
            r_xneg   <= i_xneg;
            r_yneg   <= i_yneg;
            r_xmajor <= i_xmajor;
            r_major  <= i_major;
            r_minor  <= i_minor;
            r_steps  <= i_steps;
            r_err    <= {2'b00, i_minor[COORD_BITS-1:1]};
            r_cnt    <= '0;
        end else if (r_state == BK_RUN) begin
            r_cnt <= r_cnt + 1'b1;
            r_err <= err_next;
            if (r_xmajor) begin
                r_x <= x_step;
                if (minor_step) begin
                    r_y <= y_step;
                end
            end else begin
                r_y <= y_step;
                if (minor_step) begin
                    r_x <= x_step;
                end
            end
        end
    end

    assign o_pixel_x = r_x;
    assign o_pixel_y = r_y;

endmodule

@@ src/line_rasterizer.sv @@
// Line rasterizer top level: setup front end, command queue and Bresenham stepper.
// A request accepted into an idle block reaches the outputs as its first pixel after
// the setup register, the queue write, the queue read and the load, in that order.
// Throughput: one pixel per cycle while a line is in the stepper; between lines the
// stepper passes through its idle and load states to fetch the next line.
// busy rises only when the setup register and both queue entries are all occupied.
// Reset is synchronous, active low, and clears the queue and all control state.
module line_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_pixel_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);
    import lr_pkg::*;

    // Queue entry: origin, directions, major-axis flag, deltas and pixel count.
    localparam int ENTRY_W = 4 * COORD_BITS + 3 + STEP_W;

    logic                  push, full, pop, empty;
    logic [COORD_BITS-1:0] f_x0, f_y0, f_major, f_minor;
    logic                  f_xneg, f_yneg, f_xmajor;
    logic [STEP_W-1:0]     f_steps;
    logic [COORD_BITS-1:0] b_x0, b_y0, b_major, b_minor;
    logic                  b_xneg, b_yneg, b_xmajor;
    logic [STEP_W-1:0]     b_steps;
    logic [ENTRY_W-1:0]    wr_entry, rd_entry;

    // Classify the request and hold it until the queue has room.
    lr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_push    (push),
        .i_full    (full),
        .o_x0      (f_x0),
        .o_y0      (f_y0),
        .o_xneg    (f_xneg),
        .o_yneg    (f_yneg),
        .o_xmajor  (f_xmajor),
        .o_major   (f_major),
        .o_minor   (f_minor),
        .o_steps   (f_steps)
    );

    assign wr_entry = {f_x0, f_y0, f_xneg, f_yneg, f_xmajor, f_major, f_minor, f_steps};

    // Decouple setup from stepping so a new request lands while a line is drawn.
    lr_queue #(.DATA_W(ENTRY_W)) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_entry),
        .o_full    (full),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_rd_data (rd_entry)
    );

    assign {b_x0, b_y0, b_xneg, b_yneg, b_xmajor, b_major, b_minor, b_steps} = rd_entry;

    // Advance one pixel per cycle while a line runs; the receiver takes every strobe.
    lr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_x0          (b_x0),
        .i_y0          (b_y0),
        .i_xneg        (b_xneg),
        .i_yneg        (b_yneg),
        .i_xmajor      (b_xmajor),
        .i_major       (b_major),
        .i_minor       (b_minor),
        .i_steps       (b_steps),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

@@ src/lr_checker.sv @@
// Port-level checks for the line rasterizer, bound to the top level.
module lr_checker #(
    parameter int COORD_BITS = 6
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [COORD_BITS-1:0] i_start_x,
    input logic [COORD_BITS-1:0] i_start_y,
    input logic [COORD_BITS-1:0] i_end_x,
    input logic [COORD_BITS-1:0] i_end_y,
    input logic                  o_pixel_valid,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_last_pixel
);

    // Reset empties the block: no pixel and no busy right after it.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pixel_valid && !busy)
        else $error("pixel or busy right after reset");

    // A line streams without gaps until its last pixel.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_valid && !o_last_pixel |=> o_pixel_valid)
        else $error("gap inside a line");

    // Consecutive pixels of a line move by at most one on each axis.
    a_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_valid && !o_last_pixel |=>
            (o_pixel_x == $past(o_pixel_x) ||
             o_pixel_x == COORD_BITS'($past(o_pixel_x) + 1'b1) ||
             o_pixel_x == COORD_BITS'($past(o_pixel_x) - 1'b1)) &&
            (o_pixel_y == $past(o_pixel_y) ||
             o_pixel_y == COORD_BITS'($past(o_pixel_y) + 1'b1) ||
             o_pixel_y == COORD_BITS'($past(o_pixel_y) - 1'b1)))
        else $error("pixel step larger than one");

    // Consecutive pixels of a line never repeat a position.
    a_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_valid && !o_last_pixel |=>
            !(o_pixel_x == $past(o_pixel_x) && o_pixel_y == $past(o_pixel_y)))
        else $error("pixel repeated within a line");

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);

@@ dv/line_rasterizer_checker.sv @@
// Scoreboard for the line rasterizer: predicts each line's pixels and checks the pixel stream.
module line_rasterizer_checker #(
    parameter int COORD_BITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic                  i_pixel_valid,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic                  i_last_pixel,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
    } t_pixel;

    t_pixel pixel_q[$];
    int     fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pixel_q.size();

    // Walk the line Bresenham style and queue every pixel it plots.
    function automatic void plan_line(input logic [COORD_BITS-1:0] sx, sy, ex, ey);
        int     xdir, ydir, dx, dy, major, minor, err, steps, x, y;
        logic   xmajor;
        t_pixel pix;
        xdir   = (ex < sx) ? -1 : 1;
        ydir   = (ey < sy) ? -1 : 1;
        dx     = (int'(ex) - int'(sx)) * xdir;
        dy     = (int'(ey) - int'(sy)) * ydir;
        xmajor = (dx >= dy);
        x      = sx;
        y      = sy;
        if (dx == 0 && dy == 0) begin
            pix.x    = sx;
            pix.y    = sy;
            pix.last = 1'b1;
            pixel_q.push_back(pix);
            return;
        end
        major = xmajor ? dx : dy;
        minor = xmajor ? dy : dx;
        err   = minor / 2;
        steps = (major > lr_pkg::MAX_PIXELS) ? lr_pkg::MAX_PIXELS : major;
        for (int i = 0; i < steps; i++) begin
            pix.x    = x[COORD_BITS-1:0];
            pix.y    = y[COORD_BITS-1:0];
            pix.last = (i == steps - 1);
            pixel_q.push_back(pix);
            err += minor;
            if (xmajor) begin
                x += xdir;
                if (err >= major) begin
                    y   += ydir;
                    err -= major;
                end
            end else begin
                y += ydir;
                if (err >= major) begin
                    x   += xdir;
                    err -= major;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            if (i_pixel_valid) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel: x %0d y %0d last %0d",
                           i_pixel_x, i_pixel_y, i_last_pixel);
                    fail_count++;
                end else begin
                    want = pixel_q.pop_front();
                    if (i_pixel_x !== want.x) begin
                        $error("pixel_x: expected %0d, actual %0d", want.x, i_pixel_x);
                        fail_count++;
                    end
                    if (i_pixel_y !== want.y) begin
                        $error("pixel_y: expected %0d, actual %0d", want.y, i_pixel_y);
                        fail_count++;
                    end
                    if (i_last_pixel !== want.last) begin
                        $error("last_pixel: expected %0d, actual %0d",
                               want.last, i_last_pixel);
                        fail_count++;
                    end
                end
            end
            // Queue after the compare: a new line's pixels never show the same cycle.
            if (i_start && !i_busy)
                plan_line(i_start_x, i_start_y, i_end_x, i_end_y);
        end
    end

endmodule

@@ dv/line_rasterizer_tb.sv @@
// Testbench top for the line rasterizer: clock, reset, line requests and the verdict.
module line_rasterizer_tb;

    localparam int COORD_BITS = 6;
    localparam int CMAX       = (1 << COORD_BITS) - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [COORD_BITS-1:0] i_start_x;
    logic [COORD_BITS-1:0] i_start_y;
    logic [COORD_BITS-1:0] i_end_x;
    logic [COORD_BITS-1:0] i_end_y;
    logic                  o_pixel_valid;
    logic [COORD_BITS-1:0] o_pixel_x;
    logic [COORD_BITS-1:0] o_pixel_y;
    logic                  o_last_pixel;
    int                    fail_count;
    int                    pending;

    // Percent chance per cycle that the request side sits idle.
    int idle_pct = 0;

    always #5 i_clk = ~i_clk;

    line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_pixel_valid(o_pixel_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

    line_rasterizer_checker #(.COORD_BITS(COORD_BITS)) u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_pixel_valid(o_pixel_valid),
        .i_pixel_x    (o_pixel_x),
        .i_pixel_y    (o_pixel_y),
        .i_last_pixel (o_last_pixel),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Issue one line request and hold it until the block takes it.
    // Called right after a rising edge; returns at the edge that accepts it,
    // with start still high so a back-to-back request needs no second write.
    task automatic send_line(input int sx, sy, ex, ey);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
            gap++;
        // Drop start for the idle stretch, then raise it with the new request.
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_start_x <= sx[COORD_BITS-1:0];
        i_start_y <= sy[COORD_BITS-1:0];
        i_end_x   <= ex[COORD_BITS-1:0];
        i_end_y   <= ey[COORD_BITS-1:0];
        // busy read here is the value seen by the edge that just passed.
        do
            @(posedge i_clk);
        while (busy);
    endtask

    // Pick a random line: short strokes most often, so many lines pass quickly,
    // with full-range, axis-aligned, diagonal and zero-length ones mixed in.
    task automatic random_line();
        int sx, sy, ex, ey, d, kind;
        sx   = $urandom_range(CMAX);
        sy   = $urandom_range(CMAX);
        kind = $urandom_range(99);
        if (kind < 30) begin
            ex = $urandom_range(CMAX);
            ey = $urandom_range(CMAX);
        end else if (kind < 65) begin
            ex = (sx + $urandom_range(16) - 8) & CMAX;
            ey = (sy + $urandom_range(16) - 8) & CMAX;
        end else if (kind < 90) begin
            // Axis-aligned or diagonal, exact unless only one axis wraps: diagonals hit the tie between the axes.
            d  = $urandom_range(CMAX);
            ex = ($urandom_range(1) ? sx + d : sx - d) & CMAX;
            ey = ($urandom_range(1) ? sy + d : sy - d) & CMAX;
            case ($urandom_range(2))
                0: ex = sx;
                1: ey = sy;
                default: ;
            endcase
        end else begin
            ex = sx;
            ey = sy;
        end
        send_line(sx, sy, ex, ey);
    endtask

    initial begin
        int phase_pct[4] = '{0, 71, 0, 10};
        int waited;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_start_x <= '0;
        i_start_y <= '0;
        i_end_x   <= '0;
        i_end_y   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines: zero length, unit length, full-span axis lines,
        // diagonals (ties go to x), every octant, odd minor deltas for the
        // rounded-down starting error, and alternating coordinate bits.
        send_line(0, 0, 0, 0);
        send_line(CMAX, CMAX, CMAX, CMAX);
        send_line(17, 42, 17, 42);
        send_line(5, 5, 6, 5);
        send_line(0, 0, CMAX, 0);
        send_line(CMAX, CMAX, 0, CMAX);
        send_line(0, 0, 0, CMAX);
        send_line(CMAX, CMAX, CMAX, 0);
        send_line(0, 0, CMAX, CMAX);
        send_line(CMAX, 0, 0, CMAX);
        send_line(10, 10, 30, 15);
        send_line(30, 15, 10, 10);
        send_line(10, 10, 15, 30);
        send_line(15, 30, 10, 10);
        send_line(10, 30, 30, 25);
        send_line(30, 25, 10, 30);
        send_line(20, 10, 17, 40);
        send_line(17, 40, 20, 10);
        send_line(0, 0, 7, 3);
        send_line(0, 0, 3, 7);
        send_line(42, 21, 21, 42);
        send_line(21, 42, 42, 21);

        // Random lines in phases of request-side idling: none, heavy, none, light.
        foreach (phase_pct[p]) begin
            idle_pct = phase_pct[p];
            repeat (37) random_line();
        end
        start <= 1'b0;
        // Let the scoreboard queue the last accepted line before reading pending.
        @(posedge i_clk);

        // Drain: wait for every predicted pixel, then watch for strays.
        waited = 0;
        while (pending != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hang guard: the slowest legal run is well under a tenth of this.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
